// ----- hdl/gdrc_pkg.sv -----
// Package for the grid DDA ray caster: word types, datapath command codes,
// status struct and fixed widths. No dependencies.
package gdrc_pkg;

  localparam int DEF_MAP_W       = 16;
  localparam int DEF_MAP_H       = 16;
  localparam int DEF_TILE_PIXELS = 32;
  localparam int DEF_SCREEN_W    = 512;
  localparam int DEF_SCREEN_H    = 256;
  localparam int DEF_MAX_STEPS   = 32;

  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = 8;
  localparam int KIND_W      = 2;
  localparam int DIV_W       = 35;
  localparam int COST_W      = 41;
  localparam int RD_W        = 22;
  localparam int CAM_W       = 20;
  localparam int MC_W        = 10;
  localparam int ADDR_W      = 13;
  localparam int H_W         = 12;
  localparam int OFF_W       = 7;
  localparam logic [19:0] DIST_MAX = 20'hfffff;
  localparam logic [7:0]  SHADE_MAX = 8'hff;

  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_DGO  = 4'd2;
  localparam logic [3:0] OP_DPUT = 4'd3;
  localparam logic [3:0] OP_MULX = 4'd4;
  localparam logic [3:0] OP_RDX  = 4'd5;
  localparam logic [3:0] OP_MULY = 4'd6;
  localparam logic [3:0] OP_RDY  = 4'd7;
  localparam logic [3:0] OP_STEP = 4'd8;
  localparam logic [3:0] OP_HIT  = 4'd9;
  localparam logic [3:0] OP_MISS = 4'd10;

  localparam logic [3:0] DS_PX  = 4'd0;
  localparam logic [3:0] DS_PY  = 4'd1;
  localparam logic [3:0] DS_CAM = 4'd2;
  localparam logic [3:0] DS_DX  = 4'd3;
  localparam logic [3:0] DS_DY  = 4'd4;
  localparam logic [3:0] DS_CX  = 4'd5;
  localparam logic [3:0] DS_CY  = 4'd6;
  localparam logic [3:0] DS_HT  = 4'd7;
  localparam logic [3:0] DS_SHD = 4'd8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [7:0]        tile_index;
    logic [1:0]        tile_kind;
    logic [8:0]        pos_x;
    logic [8:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic [8:0]        ray_column;
  } in_t;

  typedef struct packed {
    logic [8:0]  out_column;
    logic        hit_valid;
    logic [3:0]  hit_tile_x;
    logic [3:0]  hit_tile_y;
    logic        hit_side;
    logic [1:0]  hit_kind;
    logic [19:0] wall_distance;
    logic [8:0]  line_height;
    logic [7:0]  shade;
  } out_t;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] dsel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic zero_ray;
    logic out_map;
    logic tile_hit;
    logic steps_done;
  } status_t;

endpackage

// ----- hdl/gdrc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gdrc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/gdrc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module gdrc_div #(
  parameter int W = 35
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [W:0]    sh, diff;

  assign sh   = {rem_r, quo_r[W-1]};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (run_r) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= sh[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ----- hdl/gdrc_dp.sv -----
// Datapath of the ray caster: input registers, tile store, shared divider,
// multiplier and DDA walk registers. Depends on gdrc_pkg, gdrc_ram, gdrc_div.
module gdrc_dp import gdrc_pkg::*; #(
  parameter int MAP_W       = DEF_MAP_W,
  parameter int MAP_H       = DEF_MAP_H,
  parameter int TILE_PIXELS = DEF_TILE_PIXELS,
  parameter int SCREEN_W    = DEF_SCREEN_W,
  parameter int SCREEN_H    = DEF_SCREEN_H,
  parameter int MAX_STEPS   = DEF_MAX_STEPS
) (
  input  logic    clk,
  input  logic    rst_n,
  input  in_t     in_word,
  input  cmd_t    cmd,
  output status_t status,
  output logic    out_valid,
  output out_t    out_word
);

  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic [COST_W-1:0] COST_INF = COST_W'(1) << 40;

  logic [8:0]               col_r, px_r, py_r;
  logic signed [15:0]       dirx_r, diry_r, plx_r, ply_r;
  logic signed [CAM_W-1:0]  cam_r;
  logic signed [35:0]       prod_r;
  logic signed [RD_W-1:0]   rdx_r, rdy_r;
  logic signed [MC_W-1:0]   mx_r, my_r;
  logic [OFF_W-1:0]         offx_r, offy_r;
  logic [COST_W-1:0]        dx_r, dy_r, cx_r, cy_r, dist_r;
  logic                     side_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [H_W-1:0]           h_r;
  logic [7:0]               shade_r;
  logic [STORE_DEPTH-1:0]   valid_r;
  logic                     vld_q_r;
  logic                     out_valid_r;
  out_t                     out_r;

  logic [KIND_W-1:0] ram_q, kind_eff;
  logic              ram_we;
  logic [ADDR_W-1:0] afull;
  logic              in_store;
  logic              div_go, div_done;
  logic [DIV_W-1:0]  dnum, dden, quo;
  logic signed [12:0] ncol;
  logic [11:0]        ncmag;
  logic [25:0]        camq;
  logic [RD_W-1:0]    ax, ay;
  logic [35:0]        pmag;
  logic [21:0]        ptr;
  logic signed [RD_W-1:0] rd_nxt;
  logic [OFF_W-1:0]   fracx, fracy;
  logic [35:0]        mulcx, mulcy;
  logic [35:0]        cxq, cyq;
  logic [19:0]        shq;
  out_t               miss_w;

  assign ram_we = (cmd.op == OP_LOAD) && (in_word.action == ACT_WRITE) &&
                  (ADDR_W'(in_word.tile_index) < ADDR_W'(MAP_W * MAP_H));

  assign afull = ADDR_W'(my_r) * ADDR_W'(MAP_W) + ADDR_W'(mx_r);
  assign in_store = afull < ADDR_W'(STORE_DEPTH);

  gdrc_ram #(.WIDTH(KIND_W), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_word.tile_index),
    .wdata (in_word.tile_kind),
    .raddr (afull[STORE_AW-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[in_word.tile_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r <= valid_r[afull[STORE_AW-1:0]];
  end

  assign kind_eff = (vld_q_r && in_store) ? ram_q : '0;

  assign ncol  = $signed({3'b000, col_r, 1'b0}) - $signed(13'(SCREEN_W));
  assign ncmag = ncol[12] ? 12'(-ncol) : 12'(ncol);
  assign camq  = {ncmag, 14'b0} / 26'(SCREEN_W);
  assign ax    = rdx_r[RD_W-1] ? RD_W'(-rdx_r) : RD_W'(rdx_r);
  assign ay    = rdy_r[RD_W-1] ? RD_W'(-rdy_r) : RD_W'(rdy_r);
  assign fracx = rdx_r[RD_W-1] ? offx_r : OFF_W'(TILE_PIXELS) - offx_r;
  assign fracy = rdy_r[RD_W-1] ? offy_r : OFF_W'(TILE_PIXELS) - offy_r;
  assign mulcx = 36'(fracx) * 36'(dx_r[28:0]);
  assign mulcy = 36'(fracy) * 36'(dy_r[28:0]);
  assign cxq   = mulcx / 36'(TILE_PIXELS);
  assign cyq   = mulcy / 36'(TILE_PIXELS);
  assign shq   = (20'(h_r) * 20'(SHADE_MAX)) / 20'(SCREEN_H);

  assign pmag = prod_r[35] ? 36'(-prod_r) : 36'(prod_r);
  assign ptr  = pmag[35:14];

  always_comb begin
    if (cmd.op == OP_RDX) begin
      rd_nxt = prod_r[35] ? RD_W'(dirx_r) - $signed(ptr) : RD_W'(dirx_r) + $signed(ptr);
    end else begin
      rd_nxt = prod_r[35] ? RD_W'(diry_r) - $signed(ptr) : RD_W'(diry_r) + $signed(ptr);
    end
  end

  always_comb begin
    dnum = '0;
    dden = '0;
    case (cmd.dsel)
      DS_DX: begin
        dnum = DIV_W'(1) << 28;
        dden = DIV_W'(ax);
      end
      DS_DY: begin
        dnum = DIV_W'(1) << 28;
        dden = DIV_W'(ay);
      end
      DS_HT: begin
        dnum = DIV_W'(SCREEN_H) << 14;
        dden = dist_r[DIV_W-1:0];
      end
      default: begin
        dnum = '0;
        dden = '0;
      end
    endcase
  end

  assign div_go = (cmd.op == OP_DGO);

  gdrc_div #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (dnum),
    .den   (dden),
    .quo   (quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        col_r  <= in_word.ray_column;
        px_r   <= in_word.pos_x;
        py_r   <= in_word.pos_y;
        dirx_r <= in_word.dir_x;
        diry_r <= in_word.dir_y;
        plx_r  <= in_word.plane_x;
        ply_r  <= in_word.plane_y;
        cnt_r  <= '0;
      end
      OP_DPUT: begin
        case (cmd.dsel)
          DS_PX: begin
            mx_r   <= MC_W'(px_r / 9'(TILE_PIXELS));
            offx_r <= OFF_W'(px_r % 9'(TILE_PIXELS));
          end
          DS_PY: begin
            my_r   <= MC_W'(py_r / 9'(TILE_PIXELS));
            offy_r <= OFF_W'(py_r % 9'(TILE_PIXELS));
          end
          DS_CAM: cam_r <= ncol[12] ? -$signed(CAM_W'(camq)) : $signed(CAM_W'(camq));
          DS_DX: dx_r <= (ax == '0) ? COST_INF : COST_W'(quo);
          DS_DY: dy_r <= (ay == '0) ? COST_INF : COST_W'(quo);
          DS_CX: cx_r <= (ax == '0) ? COST_INF : COST_W'(cxq);
          DS_CY: cy_r <= (ay == '0) ? COST_INF : COST_W'(cyq);
          DS_HT: begin
            if (dist_r == '0 || quo > DIV_W'(SCREEN_H)) begin
              h_r <= H_W'(SCREEN_H);
            end else begin
              h_r <= H_W'(quo);
            end
          end
          DS_SHD: shade_r <= shq[7:0];
          default: begin
          end
        endcase
      end
      OP_MULX: prod_r <= plx_r * cam_r;
      OP_MULY: prod_r <= ply_r * cam_r;
      OP_RDX: rdx_r <= rd_nxt;
      OP_RDY: rdy_r <= rd_nxt;
      OP_STEP: begin
        cnt_r <= cnt_r + 1'b1;
        if (cx_r < cy_r) begin
          dist_r <= cx_r;
          cx_r   <= cx_r + dx_r;
          mx_r   <= rdx_r[RD_W-1] ? mx_r - 1'b1 : mx_r + 1'b1;
          side_r <= 1'b0;
        end else begin
          dist_r <= cy_r;
          cy_r   <= cy_r + dy_r;
          my_r   <= rdy_r[RD_W-1] ? my_r - 1'b1 : my_r + 1'b1;
          side_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_HIT) || (cmd.op == OP_MISS);
    end
  end

  always_comb begin
    miss_w            = '0;
    miss_w.out_column = col_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_HIT) begin
      out_r.out_column    <= col_r;
      out_r.hit_valid     <= 1'b1;
      out_r.hit_tile_x    <= mx_r[3:0];
      out_r.hit_tile_y    <= my_r[3:0];
      out_r.hit_side      <= side_r;
      out_r.hit_kind      <= kind_eff;
      out_r.wall_distance <= (dist_r > COST_W'(DIST_MAX)) ? DIST_MAX : dist_r[19:0];
      out_r.line_height   <= h_r[8:0];
      out_r.shade         <= shade_r;
    end else if (cmd.op == OP_MISS) begin
      out_r <= miss_w;
    end
  end

  assign status.div_done   = div_done;
  assign status.zero_ray   = (rdx_r == '0) && (rdy_r == '0);
  assign status.out_map    = mx_r[MC_W-1] || (mx_r >= $signed(MC_W'(MAP_W))) ||
                             my_r[MC_W-1] || (my_r >= $signed(MC_W'(MAP_H)));
  assign status.tile_hit   = (kind_eff != '0);
  assign status.steps_done = (cnt_r == CNT_W'(MAX_STEPS));

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// ----- hdl/gdrc_ctrl.sv -----
// Controller state machine of the ray caster: sequences divisions, products
// and the grid walk. Depends on gdrc_pkg.
module gdrc_ctrl import gdrc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_action,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PX    = 5'd1;
  localparam logic [4:0] S_PY    = 5'd2;
  localparam logic [4:0] S_CAM   = 5'd3;
  localparam logic [4:0] S_MULX  = 5'd4;
  localparam logic [4:0] S_RDX   = 5'd5;
  localparam logic [4:0] S_MULY  = 5'd6;
  localparam logic [4:0] S_RDY   = 5'd7;
  localparam logic [4:0] S_ZCHK  = 5'd8;
  localparam logic [4:0] S_DX_GO = 5'd9;
  localparam logic [4:0] S_DX_WT = 5'd10;
  localparam logic [4:0] S_DY_GO = 5'd11;
  localparam logic [4:0] S_DY_WT = 5'd12;
  localparam logic [4:0] S_CX    = 5'd13;
  localparam logic [4:0] S_CY    = 5'd14;
  localparam logic [4:0] S_STEP  = 5'd15;
  localparam logic [4:0] S_LOOK  = 5'd16;
  localparam logic [4:0] S_CHK   = 5'd17;
  localparam logic [4:0] S_HT_GO = 5'd18;
  localparam logic [4:0] S_HT_WT = 5'd19;
  localparam logic [4:0] S_SD    = 5'd20;
  localparam logic [4:0] S_HIT   = 5'd21;
  localparam logic [4:0] S_MISS  = 5'd22;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    cmd.dsel  = DS_PX;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (in_action == ACT_CAST) begin
            state_nxt = S_PX;
          end
        end
      end
      S_PX: begin
        cmd.op = OP_DPUT; cmd.dsel = DS_PX; state_nxt = S_PY;
      end
      S_PY: begin
        cmd.op = OP_DPUT; cmd.dsel = DS_PY; state_nxt = S_CAM;
      end
      S_CAM: begin
        cmd.op = OP_DPUT; cmd.dsel = DS_CAM; state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.op = OP_MULX; state_nxt = S_RDX;
      end
      S_RDX: begin
        cmd.op = OP_RDX; state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.op = OP_MULY; state_nxt = S_RDY;
      end
      S_RDY: begin
        cmd.op = OP_RDY; state_nxt = S_ZCHK;
      end
      S_ZCHK: begin
        state_nxt = status.zero_ray ? S_MISS : S_DX_GO;
      end
      S_DX_GO: begin
        cmd.op = OP_DGO; cmd.dsel = DS_DX; state_nxt = S_DX_WT;
      end
      S_DX_WT: begin
        cmd.dsel = DS_DX;
        if (status.div_done) begin
          cmd.op = OP_DPUT; state_nxt = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd.op = OP_DGO; cmd.dsel = DS_DY; state_nxt = S_DY_WT;
      end
      S_DY_WT: begin
        cmd.dsel = DS_DY;
        if (status.div_done) begin
          cmd.op = OP_DPUT; state_nxt = S_CX;
        end
      end
      S_CX: begin
        cmd.op = OP_DPUT; cmd.dsel = DS_CX; state_nxt = S_CY;
      end
      S_CY: begin
        cmd.op = OP_DPUT; cmd.dsel = DS_CY; state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.op = OP_STEP; state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = status.out_map ? S_MISS : S_CHK;
      end
      S_CHK: begin
        if (status.tile_hit) begin
          state_nxt = S_HT_GO;
        end else if (status.steps_done) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_HT_GO: begin
        cmd.op = OP_DGO; cmd.dsel = DS_HT; state_nxt = S_HT_WT;
      end
      S_HT_WT: begin
        cmd.dsel = DS_HT;
        if (status.div_done) begin
          cmd.op = OP_DPUT; state_nxt = S_SD;
        end
      end
      S_SD: begin
        cmd.op = OP_DPUT; cmd.dsel = DS_SHD; state_nxt = S_HIT;
      end
      S_HIT: begin
        cmd.op = OP_HIT; state_nxt = S_IDLE;
      end
      S_MISS: begin
        cmd.op = OP_MISS; state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hdl/grid_dda_ray_caster_unit.sv -----
// Top level of the grid DDA ray caster: controller plus datapath.
// Depends on gdrc_pkg, gdrc_ctrl and gdrc_dp.
//
// Usage: a word is taken on in_word when start is high and busy is low.
// A word with action 0 writes one map tile in that same cycle; busy stays
// low and no result follows, so writes may follow one another directly.
// A word with action 1 casts one ray; busy rises and stays high until the
// result has been formed. The result is shown on out_word for exactly one
// cycle with out_valid high, the first cycle in which busy is low again;
// the receiver cannot stall it and must take it then. A new word may be
// taken in that same cycle.
// A cast divides the two step costs and, on a hit, the wall height one
// after another on the shared one-bit-per-cycle divider; each walk step
// passes through the states S_STEP, S_LOOK and S_CHK around the registered
// tile store read. A walk without a hit gives a miss result, and a zero
// ray gives its miss result before any division.
// Reset (rst_n low, synchronous) returns the controller to idle and marks
// every tile empty at once; words may be issued on the next cycle.
module grid_dda_ray_caster_unit import gdrc_pkg::*; #(
  parameter int MAP_W       = DEF_MAP_W,
  parameter int MAP_H       = DEF_MAP_H,
  parameter int TILE_PIXELS = DEF_TILE_PIXELS,
  parameter int SCREEN_W    = DEF_SCREEN_W,
  parameter int SCREEN_H    = DEF_SCREEN_H,
  parameter int MAX_STEPS   = DEF_MAX_STEPS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_word,
  output logic out_valid,
  output out_t out_word
);

  cmd_t    cmd;
  status_t status;

  gdrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_word.action),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  gdrc_dp #(
    .MAP_W       (MAP_W),
    .MAP_H       (MAP_H),
    .TILE_PIXELS (TILE_PIXELS),
    .SCREEN_W    (SCREEN_W),
    .SCREEN_H    (SCREEN_H),
    .MAX_STEPS   (MAX_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe lasted two cycles");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.action) |=> busy) else $error("cast word not taken");
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_word.action) |=> (!busy && !out_valid))
    else $error("tile write started work");
`endif

endmodule
